FILE: design/tcw_pkg.sv
// tcw_pkg: shared codes, constants, request and result types of the text console writer
// depends on: nothing
package tcw_pkg;

  // request opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_PLACE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // control characters interpreted by append
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // space character on white-on-black attribute
  localparam logic [15:0] BLANK_CELL = 16'h0F20;
  localparam int TAB_STEP = 4;

  typedef logic [10:0] cur_out_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [7:0] color;
    logic [4:0] row;
    logic [6:0] column;
  } item_t;

  typedef struct packed {
    cur_out_t   cursor_position;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic       out_of_range;
  } res_t;

endpackage

FILE: design/tcw_cell_mem.sv
// tcw_cell_mem: character/attribute cell memory, one write and one read port
// depends on: nothing; read data registered
module tcw_cell_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= cells[raddr];
    end
  end

endmodule

FILE: design/tcw_engine.sv
// tcw_engine: request sequencer, cursor and column tracking, scroll and clear sweeps
// depends on: tcw_pkg; drives the ports of tcw_cell_mem
module tcw_engine #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int MEMORY_CELLS  = 2048,
  parameter int AW            = 11
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcw_pkg::item_t item,
  output logic           res_valid,
  input  logic           res_ready,
  output tcw_pkg::res_t  res,
  output logic           mem_we,
  output logic [AW-1:0]  mem_waddr,
  output logic [15:0]    mem_wdata,
  output logic           mem_re,
  output logic [AW-1:0]  mem_raddr,
  input  logic [15:0]    mem_rdata
);

  localparam int POS_RAW = 31 * SCREEN_WIDTH + 127;
  localparam int POS_MAX = (POS_RAW > MEMORY_CELLS) ? POS_RAW : MEMORY_CELLS;
  localparam int PW      = $clog2(POS_MAX + 1);
  localparam int IDX_RAW = (SCREEN_HEIGHT + 1) * SCREEN_WIDTH;
  localparam int IDX_MAX = (IDX_RAW > MEMORY_CELLS) ? IDX_RAW : MEMORY_CELLS;
  localparam int IW      = $clog2(IDX_MAX + 1);
  localparam int COLW    = $clog2(SCREEN_WIDTH);

  localparam logic [PW-1:0]   MEM_P     = PW'(MEMORY_CELLS);
  localparam logic [PW-1:0]   W_P       = PW'(SCREEN_WIDTH);
  localparam logic [IW-1:0]   MEM_I     = IW'(MEMORY_CELLS);
  localparam logic [IW-1:0]   W_I       = IW'(SCREEN_WIDTH);
  localparam logic [IW-1:0]   SCROLL_AT = IW'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
  localparam logic [COLW:0]   W_C       = (COLW + 1)'(SCREEN_WIDTH);
  localparam logic [COLW:0]   TAB_C     = (COLW + 1)'(tcw_pkg::TAB_STEP);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t          state;
  logic [1:0]      op;
  logic [7:0]      ch;
  logic [7:0]      color;
  logic [PW-1:0]   pos;
  logic [IW-1:0]   cursor;
  logic [COLW-1:0] col;
  logic            pend_write;
  logic [IW-1:0]   idx;
  logic            stg_valid;
  logic [IW-1:0]   stg_idx;
  logic            stg_copy;
  logic            stg_oob;
  logic [7:0]      res_char;
  logic [7:0]      res_color;
  logic            res_oor;

  logic [COLW:0]   col_tab;
  logic [COLW:0]   col_inc;
  logic [IW-1:0]   copy_limit;
  logic [IW-1:0]   idx_src;

  assign col_tab    = {1'b0, col} + TAB_C;
  assign col_inc    = {1'b0, col} + (COLW + 1)'(1);
  assign copy_limit = cursor - W_I;
  assign idx_src    = idx + W_I;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.cursor_position = tcw_pkg::cur_out_t'(cursor);
  assign res.cell_char       = res_char;
  assign res.cell_color      = res_color;
  assign res.out_of_range    = res_oor;

  // memory port selection per state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_EXEC: begin
        if (op == tcw_pkg::OP_PLACE && pos < MEM_P && ch != tcw_pkg::CH_NUL) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(pos);
          mem_wdata = {color, ch};
        end
        if (op == tcw_pkg::OP_READ && pos < MEM_P) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(pos);
        end
      end
      S_CHECK: begin
        if (cursor < SCROLL_AT && pend_write && cursor < MEM_I) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cursor);
          mem_wdata = {color, ch};
        end
      end
      S_SCROLL: begin
        // read runs one row ahead of the write
        if (idx < copy_limit && idx_src < MEM_I) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_src);
        end
        if (stg_valid && stg_idx < MEM_I) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(stg_idx);
          mem_wdata = stg_copy ? (stg_oob ? 16'h0000 : mem_rdata) : tcw_pkg::BLANK_CELL;
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx);
        mem_wdata = tcw_pkg::BLANK_CELL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cursor     <= '0;
      col        <= '0;
      pend_write <= 1'b0;
      stg_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op        <= item.opcode;
            ch        <= item.char_code;
            color     <= item.color;
            pos       <= PW'(item.row) * W_P + PW'(item.column);
            res_char  <= '0;
            res_color <= '0;
            res_oor   <= 1'b0;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op)
            tcw_pkg::OP_APPEND: begin
              case (ch)
                tcw_pkg::CH_NUL: state <= S_DONE;
                tcw_pkg::CH_TAB: begin
                  cursor <= cursor + IW'(tcw_pkg::TAB_STEP);
                  col    <= COLW'((col_tab >= W_C) ? col_tab - W_C : col_tab);
                  state  <= S_CHECK;
                end
                tcw_pkg::CH_LF: begin
                  cursor <= cursor + (W_I - IW'(col));
                  col    <= '0;
                  state  <= S_CHECK;
                end
                tcw_pkg::CH_FF: begin
                  cursor <= '0;
                  col    <= '0;
                  idx    <= '0;
                  state  <= S_CLEAR;
                end
                tcw_pkg::CH_CR: begin
                  cursor <= cursor - IW'(col);
                  col    <= '0;
                  state  <= S_DONE;
                end
                tcw_pkg::CH_BS: begin
                  if (col != '0) begin
                    cursor <= cursor - IW'(1);
                    col    <= col - COLW'(1);
                  end
                  state <= S_DONE;
                end
                tcw_pkg::CH_VT: begin
                  cursor <= cursor + W_I;
                  state  <= S_CHECK;
                end
                default: begin
                  pend_write <= 1'b1;
                  state      <= S_CHECK;
                end
              endcase
            end
            tcw_pkg::OP_PLACE: begin
              res_oor <= (pos >= MEM_P);
              state   <= S_DONE;
            end
            tcw_pkg::OP_READ: begin
              if (pos >= MEM_P) begin
                res_oor <= 1'b1;
                state   <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_READ: begin
          res_char  <= mem_rdata[7:0];
          res_color <= mem_rdata[15:8];
          state     <= S_DONE;
        end
        S_CHECK: begin
          if (cursor >= SCROLL_AT) begin
            idx       <= '0;
            stg_valid <= 1'b0;
            state     <= S_SCROLL;
          end else begin
            if (pend_write) begin
              pend_write <= 1'b0;
              cursor     <= cursor + IW'(1);
              col        <= COLW'((col_inc >= W_C) ? col_inc - W_C : col_inc);
            end
            state <= S_DONE;
          end
        end
        S_SCROLL: begin
          stg_valid <= (idx < cursor);
          stg_idx   <= idx;
          stg_copy  <= (idx < copy_limit);
          stg_oob   <= (idx_src >= MEM_I);
          if (idx < cursor) begin
            idx <= idx + IW'(1);
          end else if (!stg_valid) begin
            cursor <= copy_limit;
            state  <= S_CHECK;
          end
        end
        S_CLEAR: begin
          idx <= idx + IW'(1);
          if (idx == MEM_I - IW'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/text_console_writer.sv
// text_console_writer: top level of the text console, stream ports and result register
// depends on: tcw_pkg, tcw_cell_mem, tcw_engine
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+---------------------------------------------
//  s_*      | in        | s_tvalid/s_tready | request: opcode, char_code, color, row, column
//  m_*      | out       | m_tvalid/m_tready | result: cursor_position, cell_char,
//           |           |                   |   cell_color, out_of_range
//
// one request at a time: read, printable append, tab, newline and vertical tab pass through
// accept, execute, memory read or cursor check, and result; the rest skip the read or check
// a scroll sweeps the cells through one read and one write port, copying each row up one
// row and blanking the cells after the copy; form feed writes every cell
// rst is synchronous and clears state, cursor, column and m_tvalid; cells hold garbage until written
// the result register lets the next request in while a result waits for m_tready
module text_console_writer #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int MEMORY_CELLS  = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] opcode, [9:2] char_code, [17:10] color, [22:18] row, [29:23] column
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [10:0] cursor_position, [18:11] cell_char, [26:19] cell_color, [27] out_of_range
  output logic [31:0] m_tdata
);

  localparam int AW = $clog2(MEMORY_CELLS);
  // highest cursor that a finished request can leave behind
  localparam int CUR_MAX = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;

  tcw_pkg::item_t item;
  tcw_pkg::res_t  res;
  logic           res_valid;
  logic           res_ready;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [15:0]    mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [15:0]    mem_rdata;

  // unpack the request word, first field in the low bits
  assign item.opcode    = s_tdata[1:0];
  assign item.char_code = s_tdata[9:2];
  assign item.color     = s_tdata[17:10];
  assign item.row       = s_tdata[22:18];
  assign item.column    = s_tdata[29:23];

  tcw_engine #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MEMORY_CELLS  (MEMORY_CELLS),
    .AW            (AW)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tcw_cell_mem #(
    .DEPTH (MEMORY_CELLS),
    .AW    (AW)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register: takes a new result when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {4'b0000, res.out_of_range, res.cell_color, res.cell_char,
                  res.cursor_position};
    end
  end

  // the engine holds one request at a time
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while engine busy");

  // a position beyond the cell memory never returns cell contents
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[27] |-> m_tdata[26:11] == 16'h0000)
    else $error("out of range result carries cell data");

  // scrolling keeps the cursor at or before the first cell of the last screen row
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (CUR_MAX < 2048) |-> int'(m_tdata[10:0]) <= CUR_MAX)
    else $error("cursor left past the scroll point");

endmodule
